[hw/rtl/modbus_rtu_slave_engine_core_macros.svh]
// Assertion helpers used by mrse_ctrl of the Modbus slave engine.
`ifndef MODBUS_RTU_SLAVE_ENGINE_CORE_MACROS_SVH
`define MODBUS_RTU_SLAVE_ENGINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRSE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MRSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrse assertion failed");

`endif

[hw/rtl/mrse_pkg.sv]
`default_nettype none
package mrse_pkg;

  // Modbus function codes served by the engine.
  localparam logic [7:0] FN_READ_INPUTS = 8'd1;
  localparam logic [7:0] FN_READ_REGS   = 8'd3;
  localparam logic [7:0] FN_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FN_WRITE_COILS = 8'd15;
  localparam logic [7:0] FN_WRITE_REGS  = 8'd16;

  localparam logic [7:0] COIL_ON  = 8'hFF;
  localparam logic [7:0] COIL_OFF = 8'h00;

  // Configuration register indexes.
  localparam logic CFG_SLAVE_COUNT = 1'b0;
  localparam logic CFG_FRAME_GAP   = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic acc_byte;
    logic acc_tick;
    logic scan_start;
    logic scan_step;
    logic check_exec;
    logic wr_start;
    logic wr_step;
    logic emit_start;
    logic emit_step;
  } mrse_cmd_t;

  typedef struct packed {
    logic end_hit;
    logic pass_done;
    logic req_ok;
    logic is_write_regs;
    logic out_free;
    logic emit_last;
  } mrse_sts_t;

  // One byte of the reflected Modbus CRC16.
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/modbus_rtu_slave_engine_core.sv]
`default_nettype none
// Modbus RTU slave engine. Each input beat is either a received byte or one timer tick; a byte
// beat is taken whenever the engine is idle, and a tick that ends a frame (the tick on which the
// silent ticks since the last byte reach the configured frame gap) starts frame processing,
// during which in_stall_o stays high. Processing reads the receive buffer one byte per cycle
// to check the CRC and capture the header, validates the request in a check state, for
// function 16 reads the data bytes again at one byte per cycle, and then sends the reply one
// byte per cycle while out_stall_i is low, computing the CRC on the fly. The receive buffer
// has a single read port.
// Bytes past FRAME_BYTES are dropped; requests that fail any check produce no reply beats.
// Configuration writes (index 0 slave count, index 1 frame gap) take effect at once and are
// meant to be made while no frame is being handled.
module modbus_rtu_slave_engine_core
  import mrse_pkg::*;
#(
  parameter int REG_COUNT   = 16,
  parameter int FRAME_BYTES = 64,
  parameter int INPUT_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [15:0] digital_inputs_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       tx_byte_o,
  output logic             last_byte_o,
  output logic [3:0]       relay_state_o
);

  mrse_cmd_t cmd;
  mrse_sts_t sts;

  // Sequencing of receive, scan, validate, register write and reply.
  mrse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Buffer, CRC, register file, coils and the output register.
  mrse_dpath #(
    .REG_COUNT   (REG_COUNT),
    .FRAME_BYTES (FRAME_BYTES),
    .INPUT_BITS  (INPUT_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .rx_byte_i        (rx_byte_i),
    .digital_inputs_i (digital_inputs_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .tx_byte_o        (tx_byte_o),
    .last_byte_o      (last_byte_o),
    .relay_state_o    (relay_state_o)
  );

endmodule
`default_nettype wire

[hw/rtl/mrse_ctrl.sv]
`default_nettype none
`include "modbus_rtu_slave_engine_core_macros.svh"
module mrse_ctrl
  import mrse_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      action_i,
  output logic           in_stall_o,
  input  mrse_sts_t      sts_i,
  output mrse_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign acc = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.acc_byte = acc && !action_i;
        cmd_o.acc_tick = acc && action_i;
        if (acc && action_i && sts_i.end_hit) begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.pass_done) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (!sts_i.req_ok) begin
          state_d = S_IDLE;
        end else if (sts_i.is_write_regs) begin
          cmd_o.wr_start = 1'b1;
          state_d = S_WRITE;
        end else begin
          cmd_o.check_exec = 1'b1;
          cmd_o.emit_start = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_WRITE: begin
        if (sts_i.pass_done) begin
          cmd_o.emit_start = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.wr_step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.emit_step = sts_i.out_free;
        if (sts_i.out_free && sts_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `MRSE_ASSERT_NEXT(a_scan_to_check, state_q == S_SCAN && sts_i.pass_done, state_q == S_CHECK)
  `MRSE_ASSERT_NEXT(a_last_to_idle, cmd_o.emit_step && sts_i.emit_last, state_q == S_IDLE)
  `MRSE_ASSERT_SAME(a_busy_no_accept, state_q != S_IDLE, !(cmd_o.acc_byte || cmd_o.acc_tick))

endmodule
`default_nettype wire

[hw/rtl/mrse_dpath.sv]
`default_nettype none
module mrse_dpath
  import mrse_pkg::*;
#(
  parameter int REG_COUNT   = 16,
  parameter int FRAME_BYTES = 64,
  parameter int INPUT_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [15:0] digital_inputs_i,
  input  mrse_cmd_t        cmd_i,
  output mrse_sts_t        sts_o,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_byte_o,
  output logic [3:0]       relay_state_o
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int RA = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [7:0]    slave_count_q;
  logic [15:0]   gap_q;
  logic          in_frame_q;
  logic [15:0]   sil_q, sil_next, gap_eff;
  logic [LW-1:0] len_q, len_base;
  logic [15:0]   dins_q;
  logic [7:0]    rx_mem [FRAME_BYTES];
  logic [7:0]    rdata_q;
  logic [7:0]    idx_q, lim_q, rdpos_q;
  logic          rdv_q, rd_en;
  logic [15:0]   crc_q;
  logic [7:0]    hdr_q [8];
  logic [7:0]    hi_q;
  logic [15:0]   regs_q [REG_COUNT];
  logic [3:0]    coil_q;
  logic [7:0]    j_q;
  logic          out_valid_q;
  logic [7:0]    st, cnt, fn;
  logic [8:0]    span;
  logic [9:0]    len_w, need16;
  logic [7:0]    n_len, nb_in, tx_data;
  logic [16:0]   v_in;
  logic [8:0]    rd_reg_sum, wr_reg_sum;
  logic [7:0]    k_off, w_off;
  logic [15:0]   rd_reg;
  logic          req_ok;

  assign st   = hdr_q[3];
  assign cnt  = hdr_q[5];
  assign fn   = hdr_q[1];
  assign span = {1'b0, st} + {1'b0, cnt};
  assign len_w  = 10'(len_q);
  assign need16 = 10'd9 + {1'b0, cnt, 1'b0};

  // Frame timing.
  assign sil_next = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;
  assign gap_eff  = (gap_q == 16'd0) ? 16'd1 : gap_q;
  assign len_base = in_frame_q ? len_q : '0;

  // Request validation.
  always_comb begin
    logic ok;
    ok = (len_q >= LW'(2)) && (hdr_q[0] >= 8'd1) && (hdr_q[0] <= slave_count_q)
         && (crc_q == 16'd0);
    unique case (fn)
      FN_READ_INPUTS: ok = ok && (len_w >= 10'd8) && (hdr_q[2] == 8'd0)
                         && (hdr_q[4] == 8'd0) && (cnt != 8'd0)
                         && (span <= 9'(INPUT_BITS));
      FN_READ_REGS:   ok = ok && (len_w >= 10'd8) && (hdr_q[2] == 8'd0)
                         && (hdr_q[4] == 8'd0) && (cnt != 8'd0)
                         && (span <= 9'(REG_COUNT));
      FN_WRITE_COIL:  ok = ok && (len_w >= 10'd8) && (hdr_q[2] == 8'd0) && (st <= 8'd3)
                         && ((hdr_q[4] == COIL_ON) || (hdr_q[4] == COIL_OFF))
                         && (cnt == 8'd0);
      FN_WRITE_COILS: ok = ok && (len_w >= 10'd10) && (hdr_q[2] == 8'd0) && (st <= 8'd3)
                         && (hdr_q[4] == 8'd0) && (cnt != 8'd0) && (span <= 9'd4)
                         && (hdr_q[6] == 8'd1);
      FN_WRITE_REGS:  ok = ok && (hdr_q[2] == 8'd0) && (hdr_q[4] == 8'd0)
                         && (cnt != 8'd0) && (span <= 9'(REG_COUNT))
                         && (len_w >= need16);
      default:        ok = 1'b0;
    endcase
    req_ok = ok;
  end

  // Reply assembly.
  assign nb_in = (cnt + 8'd7) >> 3;
  assign n_len = (fn == FN_READ_INPUTS) ? (8'd3 + nb_in) :
                 (fn == FN_READ_REGS)   ? (8'd3 + {cnt[6:0], 1'b0}) : 8'd6;
  assign v_in  = ({1'b0, dins_q} >> st) & ((17'd1 << cnt) - 17'd1);
  assign k_off = j_q - 8'd3;
  assign rd_reg_sum = {1'b0, st} + {2'b00, k_off[7:1]};
  assign rd_reg = regs_q[rd_reg_sum[RA-1:0]];
  assign w_off = rdpos_q - 8'd8;
  assign wr_reg_sum = {1'b0, st} + {2'b00, w_off[7:1]};

  always_comb begin
    if (j_q == n_len) begin
      tx_data = crc_q[7:0];
    end else if (j_q > n_len) begin
      tx_data = crc_q[15:8];
    end else if (j_q == 8'd0) begin
      tx_data = hdr_q[0];
    end else if (j_q == 8'd1) begin
      tx_data = fn;
    end else if (fn == FN_READ_INPUTS) begin
      tx_data = (j_q == 8'd2) ? nb_in : (j_q == 8'd3) ? v_in[7:0] : v_in[15:8];
    end else if (fn == FN_READ_REGS) begin
      tx_data = (j_q == 8'd2) ? {cnt[6:0], 1'b0} :
                k_off[0] ? rd_reg[7:0] : rd_reg[15:8];
    end else begin
      tx_data = hdr_q[j_q[2:0]];
    end
  end

  assign rd_en = (cmd_i.scan_step || cmd_i.wr_step) && (idx_q < lim_q);

  assign sts_o.end_hit       = in_frame_q && (sil_next >= gap_eff);
  assign sts_o.pass_done     = !rdv_q && (idx_q >= lim_q);
  assign sts_o.req_ok        = req_ok;
  assign sts_o.is_write_regs = (fn == FN_WRITE_REGS);
  assign sts_o.out_free      = !out_valid_q || !out_stall_i;
  assign sts_o.emit_last     = (j_q == n_len + 8'd1);

  // Receive buffer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_byte && (len_base < LW'(FRAME_BYTES))) begin
      rx_mem[len_base[AW-1:0]] <= rx_byte_i;
    end
    if (rd_en) begin
      rdata_q <= rx_mem[idx_q[AW-1:0]];
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_count_q <= 8'd1;
      gap_q         <= 16'd10;
      in_frame_q    <= 1'b0;
      sil_q         <= 16'd0;
      len_q         <= '0;
      idx_q         <= 8'd0;
      lim_q         <= 8'd0;
      rdv_q         <= 1'b0;
      j_q           <= 8'd0;
      coil_q        <= 4'd0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= 16'd0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SLAVE_COUNT) begin
          slave_count_q <= cfg_data_i[7:0];
        end else begin
          gap_q <= cfg_data_i;
        end
      end
      if (cmd_i.acc_byte) begin
        in_frame_q <= 1'b1;
        sil_q      <= 16'd0;
        len_q      <= (len_base < LW'(FRAME_BYTES)) ? len_base + LW'(1) : len_base;
      end
      if (cmd_i.acc_tick && in_frame_q) begin
        if (sts_o.end_hit) begin
          in_frame_q <= 1'b0;
          sil_q      <= 16'd0;
        end else begin
          sil_q <= sil_next;
        end
      end
      if (cmd_i.scan_start) begin
        idx_q <= 8'd0;
        lim_q <= 8'(len_q);
        rdv_q <= 1'b0;
      end else if (cmd_i.wr_start) begin
        idx_q <= 8'd7;
        lim_q <= 8'd7 + {cnt[6:0], 1'b0};
        rdv_q <= 1'b0;
      end else begin
        rdv_q <= rd_en;
        if (rd_en) begin
          idx_q <= idx_q + 8'd1;
        end
      end
      if (cmd_i.wr_step && rdv_q && !rdpos_q[0]) begin
        regs_q[wr_reg_sum[RA-1:0]] <= {hi_q, rdata_q};
      end
      if (cmd_i.check_exec) begin
        if (fn == FN_WRITE_COIL) begin
          coil_q[st[1:0]] <= (hdr_q[4] == COIL_ON);
        end else if (fn == FN_WRITE_COILS) begin
          for (int i = 0; i < 4; i++) begin
            if ((8'(i) >= st) && (9'(i) < span)) begin
              coil_q[i] <= hdr_q[7][i - int'(st)];
            end
          end
        end
      end
      if (cmd_i.emit_start) begin
        j_q <= 8'd0;
      end else if (cmd_i.emit_step) begin
        j_q <= j_q + 8'd1;
      end
      if (cmd_i.emit_step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_tick && sts_o.end_hit) begin
      dins_q <= digital_inputs_i;
    end
    if (rd_en) begin
      rdpos_q <= idx_q;
    end
    if (cmd_i.scan_start || cmd_i.emit_start) begin
      crc_q <= CRC_INIT;
    end else if (cmd_i.scan_step && rdv_q) begin
      crc_q <= crc_byte(crc_q, rdata_q);
    end else if (cmd_i.emit_step && (j_q < n_len)) begin
      crc_q <= crc_byte(crc_q, tx_data);
    end
    if (cmd_i.scan_step && rdv_q && (rdpos_q < 8'd8)) begin
      hdr_q[rdpos_q[2:0]] <= rdata_q;
    end
    if (cmd_i.wr_step && rdv_q && rdpos_q[0]) begin
      hi_q <= rdata_q;
    end
    if (cmd_i.emit_step) begin
      tx_byte_o     <= tx_data;
      last_byte_o   <= sts_o.emit_last;
      relay_state_o <= coil_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
